// ===== sv/twq_pkg.sv =====
// Shared types, codes and defaults of the timing wheel event queue.
`default_nettype none

package twq_pkg;

  // Field widths of the item channels and the configuration register.
  localparam int PAYLOAD_W = 32;
  localparam int DELAY_W   = 6;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 7;

  // Largest wheel that the configuration register can select.
  localparam int SLOTS_CFG_MAX = (2 ** CFG_W) - 1;

  // Defaults of the top-level parameters.
  localparam int NUM_SLOTS_DEF  = 64;
  localparam int SLOT_DEPTH_DEF = 16;

  // Reset value of the slots-in-use register.
  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(64);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVENT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESET    = 3'd5;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [DELAY_W-1:0]   delay;
    logic [PAYLOAD_W-1:0] event_in;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] event_out;
    logic                 last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/twq_modulo.sv =====
// Iterative remainder unit: one restoring step per cycle.
`default_nettype none

module twq_modulo import twq_pkg::*; #(
  parameter int DVD_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [CFG_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [CFG_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [CFG_W-1:0] div_q, div_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CFG_W:0]   shifted;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[DVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = CFG_W'(shifted - {1'b0, div_q});
      end else begin
        rem_d = CFG_W'(shifted);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== sv/twq_count_ram.sv =====
// Slot count memory with one valid bit per slot, cleared all at once.
`default_nettype none

module twq_count_ram import twq_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_mem_q;
  logic              rd_vld_q;

  // Valid bits: a slot that was never written since the last clear reads zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem[rd_addr_i];
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_mem_q : '0;

endmodule

`default_nettype wire

// ===== sv/twq_event_ram.sv =====
// Event payload memory: one write port and one registered read port.
`default_nettype none

module twq_event_ram import twq_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_W-1:0]    wr_addr_i,
  input  wire logic [PAYLOAD_W-1:0] wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_W-1:0]    rd_addr_i,
  output logic      [PAYLOAD_W-1:0] rd_data_o
);

  logic [PAYLOAD_W-1:0] mem [DEPTH];
  logic [PAYLOAD_W-1:0] rd_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== sv/timing_wheel_event_queue_unit.sv =====
// Timing wheel event queue: command sequencer, pointer and result register.
//
// Input items carry a command (push, advance, reset), a delay and a payload
// on in_valid_i / in_data_i; the block holds in_stall_o high while it works
// on an item, so one item is in progress at a time. Results leave one by one
// on out_valid_o / out_data_o through an output register; out_stall_i holds
// that register and the sequencer waits only when it has a new result ready.
// An input item is taken even while a result still waits in the register.
// The wheel size is written on the cfg channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// Steps after acceptance: push reduces current + delay by one subtraction,
// or by the iterative remainder unit when the sum is at least twice the
// wheel size; out-of-range delay and reset go straight to the result.
// Advance emits the slot's events one per cycle while out_stall_i is low,
// then steps the pointer (or runs the remainder unit); an empty slot gives
// its single result after the step.
// Throughput is bounded by the slot count memory round trip (read, then
// modify and write) and by the one event memory read per emitted event.
// Reset clears the pointer and every slot count at once through per-slot
// valid bits, so no clearing pass is needed; the reset command does the same.
`default_nettype none

module timing_wheel_event_queue_unit import twq_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  // Only slots below the largest selectable wheel size are ever addressed.
  localparam int WHEEL_SLOTS = (NUM_SLOTS < SLOTS_CFG_MAX) ? NUM_SLOTS : SLOTS_CFG_MAX;
  localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
  localparam int CNT_W       = $clog2(SLOT_DEPTH + 1);
  localparam int SUM_W       = ((SLOT_W > DELAY_W) ? SLOT_W : DELAY_W) + 1;
  localparam int ENTRIES     = WHEEL_SLOTS * SLOT_DEPTH;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam logic [CFG_W-1:0]  WHEEL_N = CFG_W'(WHEEL_SLOTS);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(SLOT_DEPTH);
  localparam logic [ADDR_W-1:0] STRIDE  = ADDR_W'(SLOT_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MODW = 3'd2;
  localparam logic [2:0] S_PWR  = 3'd3;
  localparam logic [2:0] S_ACNT = 3'd4;
  localparam logic [2:0] S_DOUT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CFG_W-1:0]     slots_q;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [PAYLOAD_W-1:0] ev_q, ev_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  out_item_t            res_q, res_d;

  logic [CFG_W-1:0]     wheel_n;
  logic                 in_acc;
  logic                 out_free;
  logic                 last_event;
  logic                 red_ok;
  logic [SLOT_W-1:0]    red_val;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W:0]       n_ext;
  logic                 mod_start;
  logic                 mod_done;
  logic [CFG_W-1:0]     mod_rem;

  logic                 cnt_clear;
  logic                 cnt_rd_en;
  logic [SLOT_W-1:0]    cnt_rd_addr;
  logic [CNT_W-1:0]     cnt_rd_data;
  logic                 cnt_wr_en;
  logic [SLOT_W-1:0]    cnt_wr_addr;
  logic [CNT_W-1:0]     cnt_wr_data;
  logic                 ev_wr_en;
  logic [ADDR_W-1:0]    ev_wr_addr;
  logic                 ev_rd_en;
  logic [CNT_W-1:0]     ev_rd_idx;
  logic [ADDR_W-1:0]    ev_rd_addr;
  logic [PAYLOAD_W-1:0] ev_rd_data;

  // Handshakes.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Effective wheel size, saturated to the range 1 to the wheel capacity.
  always_comb begin
    if (slots_q == '0) begin
      wheel_n = CFG_W'(1);
    end else if (slots_q > WHEEL_N) begin
      wheel_n = WHEEL_N;
    end else begin
      wheel_n = slots_q;
    end
  end

  // Reduction of current + offset modulo the wheel size: one subtraction
  // covers values below twice the size, the remainder unit covers the rest.
  assign sum_ext = {1'b0, sum_q};
  assign n_ext   = (SUM_W + 1)'(wheel_n);

  always_comb begin
    red_ok    = 1'b0;
    red_val   = SLOT_W'(sum_q);
    mod_start = 1'b0;
    case (state_q)
      S_RED: begin
        if (sum_ext < n_ext) begin
          red_ok  = 1'b1;
          red_val = SLOT_W'(sum_q);
        end else if (sum_ext < (n_ext << 1)) begin
          red_ok  = 1'b1;
          red_val = SLOT_W'(sum_ext - n_ext);
        end else begin
          mod_start = 1'b1;
        end
      end
      S_MODW: begin
        red_ok  = mod_done;
        red_val = SLOT_W'(mod_rem);
      end
      default: begin
        red_ok = 1'b0;
      end
    endcase
  end

  // The event being shown is the last one of the slot.
  assign last_event = (({1'b0, idx_q} + (CNT_W + 1)'(1)) == {1'b0, cnt_q});

  // Event memory addresses: slot base plus position within the slot.
  assign ev_wr_addr = ADDR_W'(slot_q) * STRIDE + ADDR_W'(cnt_rd_data);
  assign ev_rd_addr = ADDR_W'(cur_q) * STRIDE + ADDR_W'(ev_rd_idx);

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cmd_d       = cmd_q;
    ev_d        = ev_q;
    sum_d       = sum_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    cnt_clear   = 1'b0;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = cur_q;
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = slot_q;
    cnt_wr_data = '0;
    ev_wr_en    = 1'b0;
    ev_rd_en    = 1'b0;
    ev_rd_idx   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = in_data_i.command;
          ev_d  = in_data_i.event_in;
          sum_d = SUM_W'(cur_q) + SUM_W'(in_data_i.delay);
          case (in_data_i.command)
            CMD_PUSH: begin
              if ({1'b0, in_data_i.delay} >= wheel_n) begin
                res_d   = '{status: ST_RANGE, event_out: '0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                state_d = S_RED;
              end
            end
            CMD_ADVANCE: begin
              cnt_rd_en = 1'b1;
              state_d   = S_ACNT;
            end
            CMD_RESET: begin
              cnt_clear = 1'b1;
              cur_d     = '0;
              res_d     = '{status: ST_RESET, event_out: '0, last: 1'b1};
              state_d   = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RED, S_MODW: begin
        if (red_ok) begin
          if (cmd_q == CMD_PUSH) begin
            slot_d      = red_val;
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = red_val;
            state_d     = S_PWR;
          end else begin
            cur_d   = red_val;
            state_d = (cnt_q == '0) ? S_EMIT : S_IDLE;
          end
        end else if (state_q == S_RED) begin
          state_d = S_MODW;
        end
      end

      S_PWR: begin
        if (cnt_rd_data >= DEPTH_C) begin
          res_d = '{status: ST_FULL, event_out: '0, last: 1'b1};
        end else begin
          ev_wr_en    = 1'b1;
          cnt_wr_en   = 1'b1;
          cnt_wr_addr = slot_q;
          cnt_wr_data = cnt_rd_data + CNT_W'(1);
          res_d       = '{status: ST_ACCEPTED, event_out: '0, last: 1'b1};
        end
        state_d = S_EMIT;
      end

      S_ACNT: begin
        cnt_d       = cnt_rd_data;
        idx_d       = '0;
        cnt_wr_en   = 1'b1;
        cnt_wr_addr = cur_q;
        cnt_wr_data = '0;
        sum_d       = SUM_W'(cur_q) + SUM_W'(1);
        if (cnt_rd_data == '0) begin
          res_d   = '{status: ST_EMPTY, event_out: '0, last: 1'b1};
          state_d = S_RED;
        end else begin
          ev_rd_en  = 1'b1;
          ev_rd_idx = '0;
          state_d   = S_DOUT;
        end
      end

      S_DOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status: ST_EVENT, event_out: ev_rd_data, last: last_event};
          if (last_event) begin
            state_d = S_RED;
          end else begin
            idx_d     = idx_q + CNT_W'(1);
            ev_rd_en  = 1'b1;
            ev_rd_idx = idx_q + CNT_W'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      slots_q     <= SLOTS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slots_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    cmd_q      <= cmd_d;
    ev_q       <= ev_d;
    sum_q      <= sum_d;
    slot_q     <= slot_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    res_q      <= res_d;
  end

  // Slot count memory.
  twq_count_ram #(
    .DEPTH  (WHEEL_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (CNT_W)
  ) u_count_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cnt_clear),
    .rd_en_i   (cnt_rd_en),
    .rd_addr_i (cnt_rd_addr),
    .rd_data_o (cnt_rd_data),
    .wr_en_i   (cnt_wr_en),
    .wr_addr_i (cnt_wr_addr),
    .wr_data_i (cnt_wr_data)
  );

  // Event payload memory.
  twq_event_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_event_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ev_wr_en),
    .wr_addr_i (ev_wr_addr),
    .wr_data_i (ev_q),
    .rd_en_i   (ev_rd_en),
    .rd_addr_i (ev_rd_addr),
    .rd_data_o (ev_rd_data)
  );

  // Remainder unit for large pointer offsets.
  twq_modulo #(
    .DVD_W (SUM_W)
  ) u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (sum_q),
    .divisor_i  (wheel_n),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Only event results carry a payload, and every other result closes its item.
  a_status_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_EVENT)) |->
      (out_data_o.last && (out_data_o.event_out == '0)))
    else $error("non-event result with payload or without last");

  // The reset command returns the pointer to slot zero.
  a_reset_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.command == CMD_RESET)) |=> (cur_q == '0))
    else $error("pointer not cleared by reset command");

  // Draining only runs over a nonempty slot and stays below its count.
  a_drain_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOUT) |-> ((cnt_q != '0) && (idx_q < cnt_q)))
    else $error("drain index outside slot");

  // The remainder unit returns a value below the wheel size.
  a_mod_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (mod_rem < wheel_n))
    else $error("remainder not below wheel size");

endmodule

`default_nettype wire

// ===== tb/twq_checker.sv =====
// Scoreboard for the timing wheel event queue: watches the channels, predicts and compares.
module twq_checker import twq_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int REPORT_LIMIT = 10;
  localparam int DUE_DEPTH    = 256;

  // Shadow copy of the wheel: stored payloads, fill levels and the pointer.
  logic [PAYLOAD_W-1:0] slot_events [NUM_SLOTS][SLOT_DEPTH];
  int unsigned          slot_fill [NUM_SLOTS];
  int unsigned          now_slot;
  logic [CFG_W-1:0]     wheel_cfg;

  // Results that the block still owes, oldest first, in a ring buffer.
  out_item_t   due_results [DUE_DEPTH];
  int unsigned due_head   = 0;
  int unsigned due_tail   = 0;
  int unsigned due_count  = 0;
  int          mismatches = 0;

  // The register is used clamped to the range 1 to NUM_SLOTS.
  function automatic int unsigned wheel_span(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (cfg > NUM_SLOTS) return NUM_SLOTS;
    return cfg;
  endfunction

  function automatic void owe_result(input logic [STATUS_W-1:0] status,
                                     input logic [PAYLOAD_W-1:0] payload,
                                     input logic last);
    out_item_t r;
    r.status    = status;
    r.event_out = payload;
    r.last      = last;
    due_results[due_tail] = r;
    due_tail  = (due_tail + 1) % DUE_DEPTH;
    due_count = due_count + 1;
  endfunction

  // Works out the results of one accepted item and updates the shadow wheel.
  function automatic void apply_command(input in_item_t item);
    int unsigned span;
    int unsigned slot;
    int unsigned fill;
    int unsigned k;
    span = wheel_span(wheel_cfg);
    case (item.command)
      CMD_PUSH: begin
        if (item.delay >= span) begin
          owe_result(ST_RANGE, '0, 1'b1);
        end else begin
          slot = (now_slot + item.delay) % span;
          if (slot_fill[slot] >= SLOT_DEPTH) begin
            owe_result(ST_FULL, '0, 1'b1);
          end else begin
            slot_events[slot][slot_fill[slot]] = item.event_in;
            slot_fill[slot] = slot_fill[slot] + 1;
            owe_result(ST_ACCEPTED, '0, 1'b1);
          end
        end
      end
      CMD_ADVANCE: begin
        fill = slot_fill[now_slot];
        if (fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < fill; k++) begin
            owe_result(ST_EVENT, slot_events[now_slot][k], k + 1 == fill);
          end
        end
        slot_fill[now_slot] = 0;
        // A pointer left beyond a shrunk wheel still wraps by the new size.
        now_slot = (now_slot + 1) % span;
      end
      CMD_RESET: begin
        for (k = 0; k < NUM_SLOTS; k++) begin
          slot_fill[k] = 0;
        end
        now_slot = 0;
        owe_result(ST_RESET, '0, 1'b1);
      end
      default: begin
        // The unused command code is dropped without a result.
      end
    endcase
  endfunction

  // Compares one delivered result with the oldest one owed.
  function automatic void match_result(input out_item_t got);
    out_item_t want;
    if (due_count == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("unexpected result: status %0d event %h last %0d",
                 got.status, got.event_out, got.last);
      end
      return;
    end
    want      = due_results[due_head];
    due_head  = (due_head + 1) % DUE_DEPTH;
    due_count = due_count - 1;
    if (got.status !== want.status || got.event_out !== want.event_out ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                 want.status, want.event_out, want.last,
                 got.status, got.event_out, got.last);
      end
    end
  endfunction

  // Channels are sampled at the clock edge; the counts leave as registers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_fill[k] = 0;
      end
      now_slot  = 0;
      wheel_cfg = SLOTS_RESET;
      due_head  = 0;
      due_tail  = 0;
      due_count = 0;
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        wheel_cfg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        apply_command(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        match_result(out_data_i);
      end
      pending_o <= due_count;
      errors_o  <= mismatches;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the timing wheel event queue: stimulus, stalls and the verdict.
module tb;
  import twq_pkg::*;

  localparam int          RUN_LIMIT   = 200000;
  localparam int          SETTLE      = 32;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  int         errors;
  int         pending;
  idle_mode_e idle_mode   = IDLE_NONE;
  int         hold_req    = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;
  int         cycle_count = 0;

  timing_wheel_event_queue_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  twq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 57;
      IDLE_BOTH:   return $urandom_range(0, 99) < 7;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_waits();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 57;
      IDLE_BOTH:     return $urandom_range(0, 99) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  // Result-side stall; a hold request keeps it high for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_req != hold_seen) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_seen   <= hold_req;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= receiver_waits();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [CMD_W-1:0] command,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic [PAYLOAD_W-1:0] payload);
    in_item_t item;
    item.command  = command;
    item.delay    = delay;
    item.event_in = payload;
    return item;
  endfunction

  // Mostly in-range pushes, random payloads, advances, unused codes and the odd reset.
  function automatic in_item_t random_item(input int unsigned span, input int unsigned adv_pct);
    in_item_t    item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < adv_pct) begin
      item.command = CMD_ADVANCE;
    end else if (pick < adv_pct + 4) begin
      item.command = CMD_RESET;
    end else if (pick < adv_pct + 7) begin
      item.command = CMD_UNUSED;
    end else begin
      item.command = CMD_PUSH;
    end
    if ($urandom_range(0, 99) < 85) begin
      item.delay = DELAY_W'($urandom_range(0, span - 1));
    end else begin
      item.delay = DELAY_W'($urandom_range(0, 63));
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      item.event_in = '0;
    end else if (pick < 10) begin
      item.event_in = '1;
    end else begin
      item.event_in = $urandom();
    end
    return item;
  endfunction

  // Offers one item and returns once it is taken and in_stall_o is seen low.
  task automatic send_item(input in_item_t item);
    while (sender_waits()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // Stops offering, waits for every owed result, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_wheel(input logic [CFG_W-1:0] slots);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= slots;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One setting of the wheel, one idling pattern, a run of random items.
  task automatic run_phase(input logic [CFG_W-1:0] slots, input idle_mode_e mode,
                           input int count, input int unsigned adv_pct, input bit hold);
    int unsigned span;
    int          k;
    span = (slots == '0) ? 1 : (slots > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : slots;
    write_wheel(slots);
    idle_mode <= mode;
    if (hold) begin
      hold_req <= hold_req + 1;
    end
    for (k = 0; k < count; k++) begin
      send_item(random_item(span, adv_pct));
    end
    drain();
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty advance, payload and delay extremes, two events in one
    // slot, the unused code, a slot filled past its depth and drained, reset.
    send_item(make_item(CMD_ADVANCE, '0, '0));
    send_item(make_item(CMD_PUSH, '0, '0));
    send_item(make_item(CMD_PUSH, '1, '1));
    send_item(make_item(CMD_PUSH, '0, 32'hA5A5_A5A5));
    send_item(make_item(CMD_ADVANCE, '0, '0));
    send_item(make_item(CMD_UNUSED, '1, '1));
    for (k = 0; k < SLOT_DEPTH_DEF + 1; k++) begin
      send_item(make_item(CMD_PUSH, '0, $urandom()));
    end
    send_item(make_item(CMD_ADVANCE, '0, '0));
    send_item(make_item(CMD_RESET, '0, '0));
    drain();

    // Random phases over several wheel sizes, the extremes among them.
    run_phase(7'd64,  IDLE_NONE,     40, 50, 1'b0);
    run_phase(7'd4,   IDLE_SENDER,   35, 20, 1'b0);
    run_phase(7'd1,   IDLE_RECEIVER, 30, 4,  1'b0);
    run_phase(7'd0,   IDLE_BOTH,     30, 6,  1'b0);
    run_phase(7'd127, IDLE_NONE,     35, 40, 1'b1);
    run_phase(7'd9,   IDLE_SENDER,   30, 25, 1'b0);
    run_phase(7'd100, IDLE_RECEIVER, 30, 30, 1'b0);
    run_phase(7'd2,   IDLE_BOTH,     25, 5,  1'b0);

    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
